// ===== rtl/core/hash_group_by_max_count_macros.svh =====
// Assertion macros for the group-by table RTL.
`ifndef HASH_GROUP_BY_MAX_COUNT_MACROS_SVH
`define HASH_GROUP_BY_MAX_COUNT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HGBMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hgbmc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HGBMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hgbmc: next-cycle check failed");

`endif

// ===== rtl/core/hgbmc_pkg.sv =====
// Shared constants, codes and structures of the group-by table.
`default_nettype none
package hgbmc_pkg;

    localparam int ENTRIES  = 1024;
    localparam int NCELLS   = 16;
    localparam int DATA_W   = 64;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int CELL_W   = $clog2(NCELLS);
    localparam int ROWS     = ENTRIES / NCELLS;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int ROWCNT_W = $clog2(ROWS + 1);

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_UPDATED    = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_FULL       = 3'd2,
        ST_READ_OK    = 3'd3,
        ST_READ_EMPTY = 3'd4
    } t_status;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] mx;
        logic [DATA_W-1:0] sm;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Broadcast to every cell while a lookup is in flight.
    typedef struct packed {
        logic              fetch;
        logic [DATA_W-1:0] key;
        logic [CELL_W-1:0] fetch_cell;
        logic [CNT_W-1:0]  count;
    } t_query;

    // Probe token handed from cell to cell.
    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic             hit;
        logic [IDX_W-1:0] idx;
        t_entry           ent;
    } t_tok;

    // Write request broadcast to the banks.
    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] bank;
        logic [ROW_W-1:0]  row;
        t_entry            data;
    } t_wr;

endpackage
`default_nettype wire

// ===== rtl/core/hash_group_by_max_count.sv =====
// Top level of the group-by table: controller and the chain of probe cells.
`default_nettype none
// Group-by table holding up to 1024 groups of {key, maximum, wrapping sum}, spread over a
// chain of 16 cells, each owning one RAM bank of 64 entries. A lookup streams one bank row
// per cycle into the first cell and the probe token moves one cell per cycle. An accumulate
// scans the rows in use, the stored groups divided by 16 and rounded up (64 when full); on
// an empty table nothing is scanned. A read of a stored group scans a single row, and a
// read of an empty index scans none.
// One word is worked on at a time; the input stalls until its result is registered, and a
// finished result may wait on the output while the next word is taken.
module hash_group_by_max_count
    import hgbmc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_op,
    input  wire logic signed [63:0] i_group_key,
    input  wire logic signed [63:0] i_max_operand,
    input  wire logic signed [63:0] i_sum_operand,
    input  wire logic [IDX_W-1:0]   i_read_index,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_status,
    output logic [IDX_W-1:0]        o_entry_index,
    output logic signed [63:0]      o_out_key,
    output logic signed [63:0]      o_out_max,
    output logic signed [63:0]      o_out_sum
);

    `include "hash_group_by_max_count_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [ROWCNT_W-1:0]   r_rows, n_rows;
    logic [ROWCNT_W-1:0]   r_issue, n_issue;
    logic [ROWCNT_W-1:0]   r_ret, n_ret;
    logic                  r_hit, n_hit;
    logic                  r_out_valid, n_out_valid;

    logic                  r_op;
    logic [DATA_W-1:0]     r_key, r_mx, r_sm;
    logic [IDX_W-1:0]      r_ridx;
    logic [IDX_W-1:0]      r_hit_idx;
    t_entry                r_hit_ent;

    t_status               r_out_status;
    logic [IDX_W-1:0]      r_out_idx;
    logic [DATA_W-1:0]     r_out_key, r_out_max, r_out_sum;

    t_tok                  tok [NCELLS+1];
    t_tok                  last;
    t_query                query;
    t_wr                   wr;

    logic                  in_accept;
    logic                  out_free;
    logic                  ret_last;
    logic                  finish_fire;
    logic                  is_full;
    logic                  ins;
    logic [CNT_W:0]        cnt_round;
    logic [ROWCNT_W-1:0]   acc_rows;
    logic [ROWCNT_W-1:0]   in_rows;
    logic                  read_ok_in;
    logic [DATA_W-1:0]     upd_max, upd_sum;
    t_status               res_status;
    logic [IDX_W-1:0]      res_idx;
    logic [DATA_W-1:0]     res_key, res_max, res_sum;

    assign in_accept   = i_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_stall;
    assign last        = tok[NCELLS];
    assign ret_last    = last.valid && ((r_ret + ROWCNT_W'(1)) == r_rows);
    assign finish_fire = (r_state == S_FINISH) && out_free;
    assign is_full     = r_count >= CNT_W'(ENTRIES);

    // Rows in use: stored groups over the number of banks, rounded up.
    assign cnt_round  = {1'b0, r_count} + (CNT_W + 1)'(NCELLS - 1);
    assign acc_rows   = ROWCNT_W'(cnt_round >> CELL_W);
    assign read_ok_in = {1'b0, i_read_index} < r_count;
    assign in_rows    = (i_op == OP_READ) ? (read_ok_in ? ROWCNT_W'(1) : '0) : acc_rows;

    assign query.fetch      = (r_op == OP_READ);
    assign query.key        = r_key;
    assign query.fetch_cell = r_ridx[CELL_W-1:0];
    assign query.count      = r_count;

    always_comb begin
        tok[0]       = '0;
        tok[0].valid = (r_state == S_SCAN) && (r_issue < r_rows);
        tok[0].row   = (r_op == OP_READ) ? r_ridx[IDX_W-1:CELL_W] : r_issue[ROW_W-1:0];
    end

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        hgbmc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (CELL_W'(g)),
            .i_query   (query),
            .i_wr      (wr),
            .i_tok     (tok[g]),
            .o_tok     (tok[g+1])
        );
    end

    assign upd_max = ($signed(r_mx) > $signed(r_hit_ent.mx)) ? r_mx : r_hit_ent.mx;
    assign upd_sum = r_hit_ent.sm + r_sm;

    always_comb begin
        res_status = ST_READ_EMPTY;
        res_idx    = r_ridx;
        res_key    = '0;
        res_max    = '0;
        res_sum    = '0;
        ins        = 1'b0;
        wr         = '0;
        priority if (r_op == OP_READ) begin
            if (r_hit) begin
                res_status = ST_READ_OK;
                res_key    = r_hit_ent.key;
                res_max    = r_hit_ent.mx;
                res_sum    = r_hit_ent.sm;
            end
        end else if (r_hit) begin
            res_status = ST_UPDATED;
            res_idx    = r_hit_idx;
            res_key    = r_hit_ent.key;
            res_max    = upd_max;
            res_sum    = upd_sum;
            wr.en      = finish_fire;
            wr.bank    = r_hit_idx[CELL_W-1:0];
            wr.row     = r_hit_idx[IDX_W-1:CELL_W];
            wr.data    = '{key: r_hit_ent.key, mx: upd_max, sm: upd_sum};
        end else if (is_full) begin
            res_status = ST_FULL;
            res_idx    = '0;
            res_key    = r_key;
        end else begin
            res_status = ST_INSERTED;
            res_idx    = r_count[IDX_W-1:0];
            res_key    = r_key;
            res_max    = r_mx;
            res_sum    = r_sm;
            ins        = 1'b1;
            wr.en      = finish_fire;
            wr.bank    = r_count[CELL_W-1:0];
            wr.row     = r_count[IDX_W-1:CELL_W];
            wr.data    = '{key: r_key, mx: r_mx, sm: r_sm};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rows      = r_rows;
        n_issue     = r_issue;
        n_ret       = r_ret;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_rows  = in_rows;
                    n_issue = '0;
                    n_ret   = '0;
                    n_hit   = 1'b0;
                    n_state = (in_rows == '0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (tok[0].valid) begin
                    n_issue = r_issue + ROWCNT_W'(1);
                end
                if (last.valid) begin
                    n_ret = r_ret + ROWCNT_W'(1);
                    if (last.hit) begin
                        n_hit = 1'b1;
                    end
                end
                if (ret_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (ins) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rows      <= '0;
            r_issue     <= '0;
            r_ret       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rows      <= n_rows;
            r_issue     <= n_issue;
            r_ret       <= n_ret;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= i_op;
            r_key  <= i_group_key;
            r_mx   <= i_max_operand;
            r_sm   <= i_sum_operand;
            r_ridx <= i_read_index;
        end
        if ((r_state == S_SCAN) && last.valid && last.hit) begin
            r_hit_idx <= last.idx;
            r_hit_ent <= last.ent;
        end
        if (finish_fire) begin
            r_out_status <= res_status;
            r_out_idx    <= res_idx;
            r_out_key    <= res_key;
            r_out_max    <= res_max;
            r_out_sum    <= res_sum;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_index = r_out_idx;
    assign o_out_key     = r_out_key;
    assign o_out_max     = r_out_max;
    assign o_out_sum     = r_out_sum;

    // Keys are unique in the table, so a lookup can hit at most once.
    `HGBMC_ASSERT_IMP(a_single_hit, i_clk, i_rst_n, last.valid && last.hit, !r_hit)
    `HGBMC_ASSERT_IMP(a_tok_in_scan, i_clk, i_rst_n, last.valid, r_state == S_SCAN)
    `HGBMC_ASSERT_NXT(a_insert_count, i_clk, i_rst_n, finish_fire && ins, r_count == $past(r_count) + CNT_W'(1))
    `HGBMC_ASSERT_NXT(a_hold_result, i_clk, i_rst_n, (r_state == S_FINISH) && r_out_valid && i_stall, r_out_valid && (r_state == S_FINISH))

endmodule
`default_nettype wire

// ===== rtl/core/hgbmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hgbmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/hgbmc_cell.sv =====
// One cell of the probe chain: a bank of group entries and a token stage.
`default_nettype none
module hgbmc_cell
    import hgbmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CELL_W-1:0] i_cell_id,
    input  wire t_query            i_query,
    input  wire t_wr               i_wr,
    input  wire t_tok              i_tok,
    output t_tok                   o_tok
);

    logic               r_valid;
    t_tok               r_tok;
    logic [ENTRY_W-1:0] rd_bits;
    t_entry             rd_ent;
    logic [IDX_W-1:0]   slot_idx;
    logic               slot_used;
    logic               match;

    // The bank holds entries whose insertion index ends in this cell's id.
    hgbmc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROWS)
    ) u_bank (
        .i_clk   (i_clk),
        .i_we    (i_wr.en && (i_wr.bank == i_cell_id)),
        .i_waddr (i_wr.row),
        .i_wdata (i_wr.data),
        .i_raddr (i_tok.row),
        .o_rdata (rd_bits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= i_tok;
    end

    assign rd_ent    = t_entry'(rd_bits);
    assign slot_idx  = {r_tok.row, i_cell_id};
    assign slot_used = {1'b0, slot_idx} < i_query.count;
    assign match     = i_query.fetch ? (i_query.fetch_cell == i_cell_id)
                                     : (rd_ent.key == i_query.key);

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_valid;
        if (r_valid && !r_tok.hit && slot_used && match) begin
            o_tok.hit = 1'b1;
            o_tok.idx = slot_idx;
            o_tok.ent = rd_ent;
        end
    end

endmodule
`default_nettype wire

// ===== bench/tb_hash_group_by_max_count.sv =====
// Self-checking testbench for the group-by table with maximum and wrapping sum per group.
`default_nettype none
module tb_hash_group_by_max_count;
    import hgbmc_pkg::*;

    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_ONE = 64'sd1;
    localparam logic signed [63:0] S64_NEG = -64'sd1;
    localparam logic signed [63:0] PAT_A   = 64'sh5555_5555_5555_5555;
    localparam logic signed [63:0] PAT_B   = 64'shAAAA_AAAA_AAAA_AAAA;
    localparam int RANDOM_PER_PHASE = 177;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct {
        logic                    op;
        logic signed [63:0]      group_key;
        logic signed [63:0]      max_operand;
        logic signed [63:0]      sum_operand;
        logic [IDX_W-1:0]        read_index;
    } t_agg_word;

    typedef struct {
        t_status                 status;
        logic [IDX_W-1:0]        entry_index;
        logic signed [63:0]      out_key;
        logic signed [63:0]      out_max;
        logic signed [63:0]      out_sum;
    } t_agg_result;

    typedef struct {
        t_agg_word               word;
        bit                      typed;
        t_agg_result             want;
    } t_directed_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_op;
    logic signed [63:0]      i_group_key;
    logic signed [63:0]      i_max_operand;
    logic signed [63:0]      i_sum_operand;
    logic [IDX_W-1:0]        i_read_index;
    logic                    o_valid;
    logic                    i_stall;
    logic [2:0]              o_status;
    logic [IDX_W-1:0]        o_entry_index;
    logic signed [63:0]      o_out_key;
    logic signed [63:0]      o_out_max;
    logic signed [63:0]      o_out_sum;

    // Predicted contents of the table.
    logic signed [63:0]      group_keys [ENTRIES];
    logic signed [63:0]      group_max  [ENTRIES];
    logic signed [63:0]      group_sum  [ENTRIES];
    int                      slot_of_key [bit [63:0]];
    int                      groups_held = 0;

    t_agg_result             pending_results [$];
    t_directed_row           directed_rows [$];
    int                      mismatch_total = 0;
    int                      tx_idle_pct = 0;
    int                      rx_idle_pct = 0;
    bit                      hold_request = 1'b0;

    hash_group_by_max_count u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_group_key   (i_group_key),
        .i_max_operand (i_max_operand),
        .i_sum_operand (i_sum_operand),
        .i_read_index  (i_read_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_entry_index (o_entry_index),
        .o_out_key     (o_out_key),
        .o_out_max     (o_out_max),
        .o_out_sum     (o_out_sum)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_agg_result fold_into_groups(input t_agg_word w);
        t_agg_result r;
        int slot;
        r = '{ST_READ_EMPTY, w.read_index, '0, '0, '0};
        if (w.op == OP_READ) begin
            if (int'(w.read_index) < groups_held) begin
                r = '{ST_READ_OK, w.read_index, group_keys[w.read_index],
                      group_max[w.read_index], group_sum[w.read_index]};
            end
        end else if (slot_of_key.exists(w.group_key)) begin
            slot = slot_of_key[w.group_key];
            if (w.max_operand > group_max[slot]) begin
                group_max[slot] = w.max_operand;
            end
            group_sum[slot] = group_sum[slot] + w.sum_operand;
            r = '{ST_UPDATED, IDX_W'(slot), group_keys[slot], group_max[slot], group_sum[slot]};
        end else if (groups_held >= ENTRIES) begin
            r = '{ST_FULL, '0, w.group_key, '0, '0};
        end else begin
            slot = groups_held;
            group_keys[slot] = w.group_key;
            group_max[slot] = w.max_operand;
            group_sum[slot] = w.sum_operand;
            slot_of_key[w.group_key] = slot;
            groups_held = groups_held + 1;
            r = '{ST_INSERTED, IDX_W'(slot), w.group_key, w.max_operand, w.sum_operand};
        end
        return r;
    endfunction

    function automatic logic signed [63:0] pick_operand();
        logic signed [63:0] v;
        case ($urandom_range(9))
            0: v = S64_MIN;
            1: v = S64_MAX;
            2: v = S64_NEG;
            3: v = 64'(signed'($urandom_range(20)) - 10);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Appends one row to the directed table.
    task automatic add_row(input t_agg_word w, input bit typed, input t_agg_result want);
        directed_rows.insert(directed_rows.size(), '{w, typed, want});
    endtask

    // Offers one word, waits for it to be taken and queues its expected result.
    task automatic push_word(input t_agg_word w, input bit typed, input t_agg_result want);
        t_agg_result r;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid       <= 1'b1;
        i_op          <= w.op;
        i_group_key   <= w.group_key;
        i_max_operand <= w.max_operand;
        i_sum_operand <= w.sum_operand;
        i_read_index  <= w.read_index;
        do @(posedge i_clk); while (o_stall);
        r = fold_into_groups(w);
        pending_results.insert(pending_results.size(), typed ? want : r);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stall, plus one long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_agg_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_total = mismatch_total + 1;
                if (mismatch_total <= 10) begin
                    $display("unexpected result word: status %0d index %0d key %h",
                             o_status, o_entry_index, o_out_key);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_entry_index !== want.entry_index ||
                    o_out_key !== want.out_key || o_out_max !== want.out_max ||
                    o_out_sum !== want.out_sum) begin
                    mismatch_total = mismatch_total + 1;
                    if (mismatch_total <= 10) begin
                        $display("result mismatch: expected st %0d idx %0d key %h max %h sum %h",
                                 want.status, want.entry_index, want.out_key,
                                 want.out_max, want.out_sum);
                        $display("                 actual   st %0d idx %0d key %h max %h sum %h",
                                 o_status, o_entry_index, o_out_key, o_out_max, o_out_sum);
                    end
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("hash_group_by_max_count regression: fail");
        $finish;
    end

    initial begin
        t_agg_word w;
        t_agg_result none;
        int ph;
        int n;
        int pick;

        none = '{ST_UPDATED, '0, '0, '0, '0};
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_op          <= OP_ACCUM;
        i_group_key   <= '0;
        i_max_operand <= '0;
        i_sum_operand <= '0;
        i_read_index  <= '0;

        // Extremes, wrap of the sum, equal maximum, reads of filled and empty indexes.
        add_row('{OP_READ, PAT_A, PAT_B, PAT_A, 10'd0}, 1'b1,
                '{ST_READ_EMPTY, 10'd0, '0, '0, '0});
        add_row('{OP_READ, PAT_B, PAT_A, PAT_B, 10'h3FF}, 1'b1,
                '{ST_READ_EMPTY, 10'h3FF, '0, '0, '0});
        add_row('{OP_ACCUM, S64_MIN, S64_MAX, S64_MAX, 10'h3FF}, 1'b1,
                '{ST_INSERTED, 10'd0, S64_MIN, S64_MAX, S64_MAX});
        add_row('{OP_ACCUM, S64_MIN, S64_MIN, S64_ONE, 10'd0}, 1'b1,
                '{ST_UPDATED, 10'd0, S64_MIN, S64_MAX, S64_MIN});
        add_row('{OP_ACCUM, S64_MAX, S64_MIN, S64_MIN, 10'h155}, 1'b1,
                '{ST_INSERTED, 10'd1, S64_MAX, S64_MIN, S64_MIN});
        add_row('{OP_ACCUM, S64_MAX, S64_NEG, S64_MIN, 10'h2AA}, 1'b1,
                '{ST_UPDATED, 10'd1, S64_MAX, S64_NEG, '0});
        add_row('{OP_ACCUM, '0, '0, '0, 10'd0}, 1'b1,
                '{ST_INSERTED, 10'd2, '0, '0, '0});
        add_row('{OP_ACCUM, '0, '0, PAT_A, 10'h3FF}, 1'b0, none);
        add_row('{OP_ACCUM, S64_NEG, S64_NEG, S64_NEG, 10'd0}, 1'b1,
                '{ST_INSERTED, 10'd3, S64_NEG, S64_NEG, S64_NEG});
        add_row('{OP_ACCUM, PAT_A, PAT_B, PAT_B, 10'd0}, 1'b1,
                '{ST_INSERTED, 10'd4, PAT_A, PAT_B, PAT_B});
        add_row('{OP_ACCUM, PAT_B, PAT_A, PAT_A, 10'h3FF}, 1'b1,
                '{ST_INSERTED, 10'd5, PAT_B, PAT_A, PAT_A});
        add_row('{OP_ACCUM, PAT_A, PAT_A, PAT_A, 10'h2AA}, 1'b0, none);
        add_row('{OP_ACCUM, '0, S64_MIN, S64_NEG, 10'h155}, 1'b0, none);
        add_row('{OP_ACCUM, S64_NEG, S64_MAX, S64_MAX, 10'd0}, 1'b0, none);
        add_row('{OP_READ, '0, '0, '0, 10'd0}, 1'b0, none);
        add_row('{OP_READ, S64_NEG, S64_NEG, S64_NEG, 10'd2}, 1'b0, none);
        add_row('{OP_READ, '0, '0, '0, 10'd5}, 1'b0, none);
        add_row('{OP_READ, '0, '0, '0, 10'd6}, 1'b1,
                '{ST_READ_EMPTY, 10'd6, '0, '0, '0});
        add_row('{OP_READ, '0, '0, '0, 10'h155}, 1'b1,
                '{ST_READ_EMPTY, 10'h155, '0, '0, '0});
        add_row('{OP_READ, '0, '0, '0, 10'h2AA}, 1'b1,
                '{ST_READ_EMPTY, 10'h2AA, '0, '0, '0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 19;
        rx_idle_pct = 85;
        foreach (directed_rows[k]) begin
            push_word(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].want);
        end

        // Random words: mostly hits on stored keys, some fresh keys and reads.
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 19;
                    rx_idle_pct = 85;
                end
                1: begin
                    // The sender waits here until every result is back.
                    i_valid <= 1'b0;
                    drain_results();
                    tx_idle_pct = 85;
                    rx_idle_pct = 19;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_request = 1'b1;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                w.op = OP_ACCUM;
                w.group_key = {$urandom, $urandom};
                w.max_operand = pick_operand();
                w.sum_operand = pick_operand();
                w.read_index = IDX_W'($urandom);
                if (pick < 20) begin
                    w.op = OP_READ;
                    if ($urandom_range(3) != 0 && groups_held > 0) begin
                        w.read_index = IDX_W'($urandom_range(groups_held - 1));
                    end
                end else if (pick < 70 && groups_held > 0) begin
                    w.group_key = group_keys[$urandom_range(groups_held - 1)];
                end else if (pick < 80) begin
                    w.group_key = 64'(signed'($urandom_range(64)) - 32);
                end
                push_word(w, 1'b0, none);
            end
        end

        i_valid <= 1'b0;
        drain_results();
        repeat (120) @(posedge i_clk);
        if (mismatch_total == 0 && pending_results.size() == 0) begin
            $display("hash_group_by_max_count regression: pass");
        end else begin
            $display("hash_group_by_max_count regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
